[design/kms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

	localparam int KEY_BITS       = 12;
	localparam int CHAR_W         = 7;
	localparam int LIMIT_W        = 4;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;
	localparam int DEF_NUM_ROWS   = 4;
	localparam int DEF_NUM_COLS   = 3;
	localparam int KEYMAP_ROWS    = 4;
	localparam int KEYMAP_COLS    = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

	// register index, taken from paddr[2]
	localparam logic REG_DEBOUNCE_LIMIT = 1'b0;

	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_STAR = 7'h2a;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_HASH = 7'h23;

	typedef struct packed {
		logic                req_type;
		logic [KEY_BITS-1:0] key_pressed;
	} req_t;

	typedef struct packed {
		logic              key_valid;
		logic [CHAR_W-1:0] key_char;
	} rsp_t;

	// 123 / 456 / 789 / *0#, anything outside the 4x3 map gives no character
	function automatic logic [CHAR_W-1:0] key_char_of(input int r, input int c);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_NONE;
		if (r < KEYMAP_ROWS && c < KEYMAP_COLS) begin
			case (r * KEYMAP_COLS + c)
				0:       ch = 7'h31;
				1:       ch = 7'h32;
				2:       ch = 7'h33;
				3:       ch = 7'h34;
				4:       ch = 7'h35;
				5:       ch = 7'h36;
				6:       ch = 7'h37;
				7:       ch = 7'h38;
				8:       ch = 7'h39;
				9:       ch = CHAR_STAR;
				10:      ch = CHAR_ZERO;
				11:      ch = CHAR_HASH;
				default: ch = CHAR_NONE;
			endcase
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

[design/kms_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module kms_scan #(
	parameter int NUM_ROWS = kms_pkg::DEF_NUM_ROWS,
	parameter int NUM_COLS = kms_pkg::DEF_NUM_COLS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           scan_en,
	input  wire logic                           read_en,
	input  wire logic [kms_pkg::KEY_BITS-1:0]   pressed,
	input  wire logic [kms_pkg::LIMIT_W-1:0]    limit,
	output kms_pkg::rsp_t                       rsp
);
	import kms_pkg::*;

	logic [NUM_COLS-1:0][NUM_ROWS-1:0] hit;
	logic [NUM_COLS-1:0]               col_hit;
	logic [NUM_COLS:0]                 no_prior;
	logic [NUM_COLS-1:0][CHAR_W-1:0]   col_char;
	logic [CHAR_W-1:0]                 cand;
	logic                              found;

	logic [CHAR_W-1:0] latched_q;
	logic              avail_q;
	logic              released_q;

	assign no_prior[0] = 1'b1;

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
		assign col_hit[c]    = |hit[c];
		assign no_prior[c+1] = no_prior[c] & ~col_hit[c];

		for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
			localparam int BIT = r * NUM_COLS + c;
			logic               p;
			logic [LIMIT_W-1:0] cnt_q;
			logic [LIMIT_W-1:0] inc;

			if (BIT < KEY_BITS) begin : g_in
				assign p = pressed[BIT];
			end else begin : g_out
				assign p = 1'b0;
			end

			assign inc    = (cnt_q < limit) ? LIMIT_W'(cnt_q + 1'b1) : cnt_q;
			assign hit[c][r] = p && (inc >= limit);

			// columns after the detecting one keep their counts
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (scan_en && no_prior[c]) begin
					cnt_q <= p ? inc : '0;
				end
			end
		end

		// highest row wins inside a column
		always_comb begin
			col_char[c] = CHAR_NONE;
			for (int r = 0; r < NUM_ROWS; r++) begin
				if (hit[c][r]) begin
					col_char[c] = key_char_of(r, c);
				end
			end
		end
	end

	assign found = ~no_prior[NUM_COLS];

	always_comb begin
		cand = CHAR_NONE;
		for (int c = 0; c < NUM_COLS; c++) begin
			if (no_prior[c] && col_hit[c]) begin
				cand = col_char[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q  <= CHAR_NONE;
			avail_q    <= 1'b0;
			released_q <= 1'b1;
		end else if (read_en) begin
			latched_q <= CHAR_NONE;
			avail_q   <= 1'b0;
		end else if (scan_en) begin
			if (!found) begin
				released_q <= 1'b1;
			end else if (released_q && !avail_q) begin
				latched_q  <= cand;
				avail_q    <= 1'b1;
				released_q <= 1'b0;
			end
		end
	end

	assign rsp.key_valid = avail_q;
	assign rsp.key_char  = avail_q ? latched_q : CHAR_NONE;

endmodule
`default_nettype wire

[design/keypad_matrix_scan_debounce.sv]
`timescale 1ns / 1ps
`default_nettype none
// Debounced keypad scanner, 4x3 matrix by default.
// Request channel (req_valid/req_ready/req): a scan tick (req_type 0) carries
// the sampled pressed bit of every key at row*NUM_COLS+col; a read
// (req_type 1) takes the latched key and clears it.
// Response channel (rsp_valid/rsp_ready/rsp): one response per read, none per
// scan. key_valid tells whether a key was latched, key_char is its ASCII code.
// A request waits in the input register; as it leaves, the debounce counters
// and latch are updated and a read's response is registered in the output
// register. Throughput: one request per cycle unless a read waits on a stalled
// response, set by the single input stage.
// A stalled response holds the output register; scans keep flowing behind it,
// only a following read waits in the input stage until the response moves.
// Reset clears all counters and the latch, marks the keypad released and sets
// debounce_limit to 3. The APB register debounce_limit sits at address 0.
module keypad_matrix_scan_debounce #(
	parameter int NUM_ROWS = kms_pkg::DEF_NUM_ROWS,
	parameter int NUM_COLS = kms_pkg::DEF_NUM_COLS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire kms_pkg::req_t                 req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output kms_pkg::rsp_t                      rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kms_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [kms_pkg::DATA_W-1:0]    pwdata,
	output logic [kms_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import kms_pkg::*;

	req_t               req_s1;
	logic               valid_s1;
	logic               s1_go;
	logic               s1_read;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	rsp_t               core_rsp;
	logic [LIMIT_W-1:0] limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEBOUNCE_LIMIT) ?
		DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_DEBOUNCE_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign s1_read   = req_s1.req_type == REQ_READ;
	assign s1_go     = valid_s1 && (!s1_read || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	kms_scan #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_en (s1_go && !s1_read),
		.read_en (s1_go && s1_read),
		.pressed (req_s1.key_pressed),
		.limit   (limit_q),
		.rsp     (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go && s1_read) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_read) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_read_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_read) |=> rsp_valid)
		else $error("read left the input stage without a response");

	a_scan_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !s1_read && !(rsp_valid && !rsp_ready)) |=> !rsp_valid)
		else $error("scan tick produced a response");

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s1_read && rsp_valid && !rsp_ready) |-> !s1_go)
		else $error("read overwrote a pending response");
`endif

endmodule
`default_nettype wire
